/* src/qslerp_pkg.sv */
`timescale 1ns / 1ps
package qslerp_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int UNIT_LAT     = 71;
  localparam int TOTAL_LAT    = 220;

  localparam logic [30:0]        ONE_Q30    = 31'd1073741824;
  localparam logic [30:0]        DOT_THRESH = 31'd1073204953;
  localparam logic [16:0]        T_ONE      = 17'd65536;
  localparam logic signed [35:0] GAIN_INV   = 36'sd652032874;

  localparam logic signed [35:0] ATAN [CORDIC_STEPS] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
    36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
    36'sd128, 36'sd64, 36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2, 36'sd1};

  typedef logic signed [31:0] q30_t;

  // shift right, round half away from zero
  function automatic logic signed [79:0] rnd_shr(input logic signed [79:0] v,
                                                 input int unsigned sh);
    logic [79:0] mag;
    logic [79:0] half;
    logic [79:0] res;
    mag  = v[79] ? 80'(-v) : 80'(v);
    half = (sh == 0) ? 80'd0 : (80'd1 << (sh - 1));
    res  = (mag + half) >> sh;
    return v[79] ? -$signed(res) : $signed(res);
  endfunction

endpackage

/* src/qslerp_delay.sv */
`timescale 1ns / 1ps
module qslerp_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);
  logic [W-1:0] sr [D];

  always_ff @(posedge clk) begin
    sr[0] <= d_in;
    for (int i = 1; i < D; i++) sr[i] <= sr[i-1];
  end

  assign d_out = sr[D-1];
endmodule

/* src/qslerp_isqrt.sv */
`timescale 1ns / 1ps
module qslerp_isqrt (
  input  logic        clk,
  input  logic [61:0] v_in,
  output logic [30:0] root
);
  logic [62:0] vr [31];
  logic [62:0] rr [31];

  for (genvar gi = 0; gi < 31; gi++) begin : g_stage
    localparam logic [62:0] BIT = 63'(1) << (2 * (30 - gi));
    logic [62:0] pv;
    logic [62:0] pr;
    logic [62:0] trial;
    if (gi == 0) begin : g_first
      assign pv = {1'b0, v_in};
      assign pr = '0;
    end else begin : g_next
      assign pv = vr[gi-1];
      assign pr = rr[gi-1];
    end
    assign trial = pr + BIT;
    always_ff @(posedge clk) begin
      if (pv >= trial) begin
        vr[gi] <= pv - trial;
        rr[gi] <= (pr >> 1) + BIT;
      end else begin
        vr[gi] <= pv;
        rr[gi] <= pr >> 1;
      end
    end
  end

  assign root = rr[30][30:0];
endmodule

/* src/qslerp_div.sv */
`timescale 1ns / 1ps
module qslerp_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 31,
  parameter int QB    = 32
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QB-1:0]    quo
);
  localparam int RW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic [RW-1:0]    rem [QB];
  logic [DEN_W-1:0] dn  [QB];
  logic [QB-1:0]    qq  [QB];

  for (genvar gi = 0; gi < QB; gi++) begin : g_stage
    localparam int K = QB - 1 - gi;
    logic [RW-1:0]    prem;
    logic [DEN_W-1:0] pden;
    logic [QB-1:0]    pq;
    logic [RW-1:0]    sub;
    if (gi == 0) begin : g_first
      assign prem = RW'(num);
      assign pden = den;
      assign pq   = '0;
    end else begin : g_next
      assign prem = rem[gi-1];
      assign pden = dn[gi-1];
      assign pq   = qq[gi-1];
    end
    assign sub = RW'(pden) << K;
    always_ff @(posedge clk) begin
      dn[gi] <= pden;
      if (prem >= sub) begin
        rem[gi] <= prem - sub;
        qq[gi]  <= pq | (QB'(1) << K);
      end else begin
        rem[gi] <= prem;
        qq[gi]  <= pq;
      end
    end
  end

  assign quo = qq[QB-1];
endmodule

/* src/qslerp_cordic.sv */
`timescale 1ns / 1ps
module qslerp_cordic #(
  parameter bit VECTOR = 1'b0
) (
  input  logic               clk,
  input  logic signed [35:0] x_in,
  input  logic signed [35:0] y_in,
  input  logic signed [35:0] z_in,
  output logic signed [35:0] x_out,
  output logic signed [35:0] y_out,
  output logic signed [35:0] z_out
);
  localparam int N = qslerp_pkg::CORDIC_STEPS;

  logic signed [35:0] xs [N];
  logic signed [35:0] ys [N];
  logic signed [35:0] zs [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_stage
    logic signed [35:0] px;
    logic signed [35:0] py;
    logic signed [35:0] pz;
    logic signed [35:0] xsh;
    logic signed [35:0] ysh;
    logic               up;
    if (gi == 0) begin : g_first
      assign px = x_in;
      assign py = y_in;
      assign pz = z_in;
    end else begin : g_next
      assign px = xs[gi-1];
      assign py = ys[gi-1];
      assign pz = zs[gi-1];
    end
    assign xsh = px >>> gi;
    assign ysh = py >>> gi;
    if (VECTOR) begin : g_vec
      assign up = !py[35];
      always_ff @(posedge clk) begin
        if (up) begin
          xs[gi] <= px + ysh;
          ys[gi] <= py - xsh;
          zs[gi] <= pz + qslerp_pkg::ATAN[gi];
        end else begin
          xs[gi] <= px - ysh;
          ys[gi] <= py + xsh;
          zs[gi] <= pz - qslerp_pkg::ATAN[gi];
        end
      end
    end else begin : g_rot
      assign up = !pz[35];
      always_ff @(posedge clk) begin
        if (up) begin
          xs[gi] <= px - ysh;
          ys[gi] <= py + xsh;
          zs[gi] <= pz - qslerp_pkg::ATAN[gi];
        end else begin
          xs[gi] <= px + ysh;
          ys[gi] <= py - xsh;
          zs[gi] <= pz + qslerp_pkg::ATAN[gi];
        end
      end
    end
  end

  assign x_out = xs[N-1];
  assign y_out = ys[N-1];
  assign z_out = zs[N-1];
endmodule

/* src/qslerp_unit.sv */
`timescale 1ns / 1ps
module qslerp_unit (
  input  logic               clk,
  input  logic signed [33:0] q_in [4],
  output logic signed [31:0] u_out [4],
  output logic               ok
);
  logic [33:0]  abs0 [4];
  logic [33:0]  orv0;
  logic [33:0]  mag1 [4];
  logic [3:0]   sgn1;
  logic [33:0]  orv1;
  logic [5:0]   lead;
  logic [33:0]  mag2 [4];
  logic [5:0]   lead2;
  logic         zero2;
  logic [63:0]  shv [4];
  logic [29:0]  m3 [4];
  logic [59:0]  sq4 [4];
  logic [60:0]  ps5 [2];
  logic [61:0]  n2_6;
  logic [30:0]  nrt;
  logic [119:0] m3_pk;
  logic [119:0] m_pk;
  logic [60:0]  num38 [4];
  logic [30:0]  n38;
  logic [31:0]  q70 [4];
  logic [3:0]   sgn70;
  logic         zero70;
  logic [30:0]  cap [4];

  always_comb begin
    orv0 = '0;
    for (int i = 0; i < 4; i++) begin
      abs0[i] = q_in[i][33] ? 34'(-q_in[i]) : 34'(q_in[i]);
      orv0    = orv0 | abs0[i];
    end
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < 34; i++) if (orv1[i]) lead = 6'(i);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (lead2 <= 6'd29) shv[i] = 64'(mag2[i]) << (6'd29 - lead2);
      else shv[i] = 64'(mag2[i]) >> (lead2 - 6'd29);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      mag1[i] <= abs0[i];
      sgn1[i] <= q_in[i][33];
      mag2[i] <= mag1[i];
      m3[i]   <= shv[i][29:0];
      sq4[i]  <= 60'(m3[i]) * 60'(m3[i]);
    end
    orv1   <= orv0;
    lead2  <= lead;
    zero2  <= (orv1 == '0);
    ps5[0] <= 61'(sq4[0]) + 61'(sq4[1]);
    ps5[1] <= 61'(sq4[2]) + 61'(sq4[3]);
    n2_6   <= 62'(ps5[0]) + 62'(ps5[1]);
  end

  qslerp_isqrt u_isqrt (.clk(clk), .v_in(n2_6), .root(nrt));

  assign m3_pk = {m3[3], m3[2], m3[1], m3[0]};

  qslerp_delay #(.W(120), .D(34)) u_mdly (.clk(clk), .d_in(m3_pk), .d_out(m_pk));
  qslerp_delay #(.W(4), .D(69)) u_sdly (.clk(clk), .d_in(sgn1), .d_out(sgn70));
  qslerp_delay #(.W(1), .D(68)) u_zdly (.clk(clk), .d_in(zero2), .d_out(zero70));

  always_ff @(posedge clk) begin
    n38 <= nrt;
    for (int i = 0; i < 4; i++) begin
      num38[i] <= {1'b0, m_pk[i*30 +: 30], 30'd0} + 61'(nrt >> 1);
    end
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_div
    qslerp_div #(.NUM_W(61), .DEN_W(31), .QB(32)) u_div (
      .clk(clk), .num(num38[gi]), .den(n38), .quo(q70[gi])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cap[i] = (q70[i] > 32'(qslerp_pkg::ONE_Q30)) ? qslerp_pkg::ONE_Q30 : q70[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      u_out[i] <= sgn70[i] ? -$signed({1'b0, cap[i]}) : $signed({1'b0, cap[i]});
    end
    ok <= !zero70;
  end
endmodule

/* src/quaternion_slerp_core.sv */
`timescale 1ns / 1ps
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+---------------------------
// request   | start, busy, a_w..a_z, b_w..b_z, frac   | edge with start & !busy
// result    | done, r_w, r_x, r_y, r_z, degenerate    | edge ending the done cycle
//
// One request per cycle; busy stays low.
// The angle path runs through the input normalizers (square root and long division),
// the dot product, the sine square root, two 31-step CORDIC pipelines with the angle
// scaling, and the 37-step divider for the sine ratio.
// rst clears the valid pipeline only; data in flight is dropped.
// The result side has no stall: each result shows for exactly one cycle.
module quaternion_slerp_core #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic [16:0]                  frac,
  output logic                         done,
  output logic signed [COMP_WIDTH-1:0] r_w,
  output logic signed [COMP_WIDTH-1:0] r_x,
  output logic signed [COMP_WIDTH-1:0] r_y,
  output logic signed [COMP_WIDTH-1:0] r_z,
  output logic                         degenerate
);
  localparam int LAT = qslerp_pkg::TOTAL_LAT;
  localparam logic signed [79:0] LIM = 80'(1) << (COMP_WIDTH - 2);

  logic [LAT-1:0] vpipe;

  logic signed [33:0] qa [4];
  logic signed [33:0] qb [4];
  logic [16:0]        t1;
  logic [16:0]        tl;
  logic [16:0]        ts;
  logic signed [17:0] tl_s;
  logic signed [17:0] ts_s;

  logic signed [31:0] ua [4];
  logic signed [31:0] ub [4];
  logic               oka;
  logic               okb;
  logic [255:0]       uab_pk;
  logic [255:0]       uab_d;

  logic signed [63:0] dp1 [4];
  logic signed [63:0] dp2 [2];
  logic signed [63:0] dp3;
  logic signed [79:0] dr_full;
  logic signed [31:0] dr4;
  logic [30:0]        d5;
  logic               near5;
  logic signed [31:0] u0p [4];
  logic signed [31:0] u1p [4];

  logic signed [32:0] diff [4];
  logic signed [31:0] u0l1 [4];
  logic signed [31:0] u0l2 [4];
  logic signed [50:0] lp [4];
  logic signed [33:0] mix [4];
  logic signed [31:0] lu [4];
  logic               okc;
  logic [128:0]       lr_pk;
  logic [128:0]       lr_d;

  logic [61:0]        dd;
  logic [60:0]        sv;
  logic [30:0]        sq;
  logic [30:0]        d_c;
  logic [30:0]        sc;
  logic [30:0]        cxin;
  logic signed [35:0] vx;
  logic signed [35:0] vy;
  logic signed [35:0] vz;
  logic signed [53:0] thp;
  logic signed [35:0] th;
  logic signed [35:0] rx;
  logic signed [35:0] ry;
  logic signed [35:0] rz;
  logic [30:0]        sc_d;
  logic [62:0]        num6;
  logic [30:0]        den6;
  logic               neg6;
  logic               neg_d;
  logic [36:0]        quo;
  logic signed [37:0] qs;
  logic signed [33:0] s1_7;
  logic signed [33:0] s1_8;
  logic signed [33:0] s1_9;
  logic [30:0]        d_s;
  logic signed [31:0] d_ss;
  logic signed [65:0] ds8;
  logic signed [35:0] cx_d;
  logic signed [34:0] s0_9;
  logic [255:0]       u01_pk;
  logic [255:0]       u01_d;
  logic signed [67:0] pa [4];
  logic signed [67:0] pb [4];
  logic signed [68:0] sm [4];
  logic signed [39:0] rs [4];

  logic               ok_d;
  logic               near_d;
  logic               ok219;
  logic signed [39:0] v219 [4];
  logic signed [79:0] rv [4];
  logic signed [COMP_WIDTH-1:0] rout [4];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start & !busy};
    end
  end
  assign done = vpipe[LAT-1];

  assign qa[0] = 34'(a_w);
  assign qa[1] = 34'(a_x);
  assign qa[2] = 34'(a_y);
  assign qa[3] = 34'(a_z);
  assign qb[0] = 34'(b_w);
  assign qb[1] = 34'(b_x);
  assign qb[2] = 34'(b_y);
  assign qb[3] = 34'(b_z);

  always_ff @(posedge clk) begin
    t1 <= (frac > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : frac;
  end

  qslerp_unit u_unit_a (.clk(clk), .q_in(qa), .u_out(ua), .ok(oka));
  qslerp_unit u_unit_b (.clk(clk), .q_in(qb), .u_out(ub), .ok(okb));

  qslerp_delay #(.W(17), .D(76)) u_tl_dly (.clk(clk), .d_in(t1), .d_out(tl));
  qslerp_delay #(.W(17), .D(140)) u_ts_dly (.clk(clk), .d_in(t1), .d_out(ts));
  assign tl_s = $signed({1'b0, tl});
  assign ts_s = $signed({1'b0, ts});

  // dot product
  assign uab_pk = {ub[3], ub[2], ub[1], ub[0], ua[3], ua[2], ua[1], ua[0]};
  qslerp_delay #(.W(256), .D(4)) u_uab_dly (.clk(clk), .d_in(uab_pk), .d_out(uab_d));
  qslerp_delay #(.W(1), .D(147)) u_ok_dly (.clk(clk), .d_in(oka & okb), .d_out(ok_d));

  assign dr_full = qslerp_pkg::rnd_shr(80'(dp3), 30);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) dp1[i] <= ua[i] * ub[i];
    dp2[0] <= dp1[0] + dp1[1];
    dp2[1] <= dp1[2] + dp1[3];
    dp3    <= dp2[0] + dp2[1];
    if (dr_full > 80'sd1073741824) dr4 <= 32'sd1073741824;
    else if (dr_full < -80'sd1073741824) dr4 <= -32'sd1073741824;
    else dr4 <= 32'(dr_full);
    d5    <= dr4[31] ? 31'(-dr4) : 31'(dr4);
    near5 <= (dr4[31] ? 31'(-dr4) : 31'(dr4)) > qslerp_pkg::DOT_THRESH;
    for (int i = 0; i < 4; i++) begin
      u0p[i] <= $signed(uab_d[i*32 +: 32]);
      u1p[i] <= dr4[31] ? -$signed(uab_d[128 + i*32 +: 32]) : $signed(uab_d[128 + i*32 +: 32]);
    end
  end

  // near branch: lerp then renormalize
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      diff[i] <= 33'(u1p[i]) - 33'(u0p[i]);
      u0l1[i] <= u0p[i];
      u0l2[i] <= u0l1[i];
      lp[i]   <= diff[i] * tl_s;
      mix[i]  <= 34'(u0l2[i]) + 34'(qslerp_pkg::rnd_shr(80'(lp[i]), 16));
    end
  end

  qslerp_unit u_unit_c (.clk(clk), .q_in(mix), .u_out(lu), .ok(okc));

  always_comb begin
    lr_pk[128] = okc;
    for (int i = 0; i < 4; i++) lr_pk[i*32 +: 32] = okc ? lu[i] : 32'sd0;
  end
  qslerp_delay #(.W(129), .D(68)) u_lr_dly (.clk(clk), .d_in(lr_pk), .d_out(lr_d));
  qslerp_delay #(.W(1), .D(142)) u_near_dly (.clk(clk), .d_in(near5), .d_out(near_d));

  // far branch: angle, sine ratio, blend
  always_ff @(posedge clk) begin
    dd <= 62'(d5) * 62'(d5);
    sv <= 61'(62'd1 << 60) - 61'(dd);
  end

  qslerp_isqrt u_sin_sqrt (.clk(clk), .v_in({1'b0, sv}), .root(sq));
  qslerp_delay #(.W(31), .D(33)) u_dc_dly (.clk(clk), .d_in(d5), .d_out(d_c));

  always_ff @(posedge clk) begin
    sc   <= (sq == '0) ? 31'd1 : sq;
    cxin <= d_c;
  end

  qslerp_cordic #(.VECTOR(1'b1)) u_acos (
    .clk(clk), .x_in($signed(36'(cxin))), .y_in($signed(36'(sc))), .z_in(36'sd0),
    .x_out(vx), .y_out(vy), .z_out(vz)
  );

  always_ff @(posedge clk) begin
    thp <= vz * ts_s;
    th  <= 36'(qslerp_pkg::rnd_shr(80'(thp), 16));
  end

  qslerp_cordic #(.VECTOR(1'b0)) u_sincos (
    .clk(clk), .x_in(qslerp_pkg::GAIN_INV), .y_in(36'sd0), .z_in(th),
    .x_out(rx), .y_out(ry), .z_out(rz)
  );

  qslerp_delay #(.W(31), .D(64)) u_sc_dly (.clk(clk), .d_in(sc), .d_out(sc_d));

  always_ff @(posedge clk) begin
    num6 <= (63'(ry[35] ? 36'(-ry) : 36'(ry)) << 30) + 63'(sc_d >> 1);
    den6 <= sc_d;
    neg6 <= ry[35] & (rz == rz);
  end

  qslerp_div #(.NUM_W(63), .DEN_W(31), .QB(37)) u_ratio (
    .clk(clk), .num(num6), .den(den6), .quo(quo)
  );
  qslerp_delay #(.W(1), .D(37)) u_neg_dly (.clk(clk), .d_in(neg6), .d_out(neg_d));
  qslerp_delay #(.W(31), .D(137)) u_ds_dly (.clk(clk), .d_in(d5), .d_out(d_s));
  qslerp_delay #(.W(36), .D(40)) u_cx_dly (.clk(clk), .d_in(rx), .d_out(cx_d));

  assign qs   = $signed({1'b0, quo});
  assign d_ss = $signed({1'b0, d_s});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      u01_pk[i*32 +: 32]       = u0p[i];
      u01_pk[128 + i*32 +: 32] = u1p[i];
    end
  end
  qslerp_delay #(.W(256), .D(139)) u_u01_dly (.clk(clk), .d_in(u01_pk), .d_out(u01_d));

  always_ff @(posedge clk) begin
    s1_7 <= 34'(neg_d ? -qs : qs);
    s1_8 <= s1_7;
    ds8  <= d_ss * s1_7;
    s1_9 <= s1_8;
    s0_9 <= 35'(cx_d) - 35'(qslerp_pkg::rnd_shr(80'(ds8), 30));
    for (int i = 0; i < 4; i++) begin
      pa[i] <= s0_9 * $signed(u01_d[i*32 +: 32]);
      pb[i] <= s1_9 * $signed(u01_d[128 + i*32 +: 32]);
      sm[i] <= 69'(pa[i]) + 69'(pb[i]);
      rs[i] <= 40'(qslerp_pkg::rnd_shr(80'(sm[i]), 30));
    end
  end

  // select and scale to the output format
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rv[i] = qslerp_pkg::rnd_shr(80'(v219[i]), 32 - COMP_WIDTH);
      if (rv[i] > LIM) rv[i] = LIM;
      if (rv[i] < -LIM) rv[i] = -LIM;
    end
  end

  always_ff @(posedge clk) begin
    ok219 <= ok_d;
    for (int i = 0; i < 4; i++) begin
      if (!ok_d) v219[i] <= 40'sd0;
      else if (near_d) v219[i] <= 40'($signed(lr_d[i*32 +: 32]));
      else v219[i] <= rs[i];
      rout[i] <= COMP_WIDTH'(rv[i]);
    end
    degenerate <= !ok219;
  end

  assign r_w = rout[0];
  assign r_x = rout[1];
  assign r_y = rout[2];
  assign r_z = rout[3];

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> r_w == 0 && r_x == 0 && r_y == 0 && r_z == 0)
    else $error("degenerate result not zero");

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> 80'(r_w) <= LIM && 80'(r_w) >= -LIM && 80'(r_z) <= LIM && 80'(r_z) >= -LIM)
    else $error("component out of range");

  a_dot_range: assert property (@(posedge clk) disable iff (rst)
    vpipe[75] |-> d5 <= qslerp_pkg::ONE_Q30)
    else $error("dot product above one");
`endif
endmodule
